>>> design/psg_pkg.sv
// Shared types, widths and constants of the four-voice sound generator.
// No dependencies; both modules import this package.
`timescale 1ns / 1ps

package psg_pkg;

    localparam int VOICES       = 4;
    localparam int TONES        = VOICES - 1;
    localparam int COUNTER_BITS = 16;
    localparam int HP_W         = 16;
    localparam int DIVD_W       = 23;
    localparam int DIVS_W       = 17;
    localparam int DCNT_W       = $clog2(DIVD_W);

    localparam int CHIP_CLOCK   = 4000000;
    localparam int TONE_NUMER   = CHIP_CLOCK / 32;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [HP_W-1:0]         NEVER   = {HP_W{1'b1}};

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

    // Divisor that turns the sample rate into a noise threshold.
    function automatic logic [13:0] f_noise_div(input logic white, input logic level,
                                                input logic [1:0] rate);
        logic [13:0] d;
        d = 14'd1;
        if (white) begin
            case (rate)
                2'd0:    d = 14'd10000;
                2'd1:    d = 14'd5000;
                2'd2:    d = 14'd2500;
                default: d = 14'd1;
            endcase
        end else if (level) begin
            case (rate)
                2'd0:    d = 14'd125;
                2'd1:    d = 14'd250;
                2'd2:    d = 14'd500;
                default: d = 14'd1;
            endcase
        end else begin
            case (rate)
                2'd0:    d = 14'd1250;
                2'd1:    d = 14'd2500;
                2'd2:    d = 14'd5000;
                default: d = 14'd1;
            endcase
        end
        return d;
    endfunction

endpackage

>>> design/psg_if.sv
// Valid/ready channel interfaces for command items and output samples.
// Depends on nothing but the handshake convention of the block.
`timescale 1ns / 1ps

interface psg_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] write_byte;

    modport source (output valid, command, write_byte, input ready);
    modport sink   (input valid, command, write_byte, output ready);
endinterface

interface psg_smp_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

>>> design/psg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on psg_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module psg_div
    import psg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   n_trial;
    logic              n_fit;
    logic [DIVS_W:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_quo[DIVD_W-1]};
        n_fit   = n_trial >= {1'b0, r_dvs};
        n_diff  = n_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of r_quo while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_fit ? n_diff[DIVS_W-1:0] : n_trial[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], n_fit};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> design/psg_tone_noise_synthesizer.sv
// Top level of the four-voice tone and noise generator: APB registers,
// sequencer, voice state. Depends on psg_pkg, psg_if.sv and psg_div.
`timescale 1ns / 1ps

// A latch byte that sets a volume or the noise mode is handled in the idle
// state itself. A byte that changes a tone divider recomputes the half-period
// with up to two passes through the shared divider. A sample tick runs one
// divider pass for the noise threshold, one step per tone voice and one for
// the noise voice, then a second divider pass that scales the mix by the
// output divisor. The output register lets the next item start while a sample
// still waits to be taken. The user must write registers over APB at byte
// addresses 0, 4, 8 and 12 only while the block is idle; it does not enforce this.

module psg_tone_noise_synthesizer
    import psg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    psg_cmd_if.sink     i_cmd,
    psg_smp_if.source   o_smp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_RATE = 2'd0;
    localparam logic [1:0] REG_ODIV = 2'd1;
    localparam logic [1:0] REG_TUNE = 2'd2;
    localparam logic [1:0] REG_FRAC = 2'd3;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FSTART = 4'd1;
    localparam logic [3:0] S_FWAIT  = 4'd2;
    localparam logic [3:0] S_QWAIT  = 4'd3;
    localparam logic [3:0] S_NSTART = 4'd4;
    localparam logic [3:0] S_NWAIT  = 4'd5;
    localparam logic [3:0] S_TONE   = 4'd6;
    localparam logic [3:0] S_NOISE  = 4'd7;
    localparam logic [3:0] S_OSTART = 4'd8;
    localparam logic [3:0] S_OWAIT  = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    localparam logic [2:0] LATCH_NOISE_MODE = 3'd6;
    localparam logic [2:0] LATCH_NOISE_ATT  = 3'd7;

    // Configuration registers
    logic [15:0]        r_sr;
    logic [7:0]         r_odiv;
    logic signed [11:0] r_tune;
    logic               r_fe;

    // Voice state
    logic [9:0]              r_tdiv [TONES];
    logic [HP_W-1:0]         r_hp   [TONES];
    logic [7:0]              r_frac [TONES];
    logic [9:0]              r_acc  [TONES];
    logic [6:0]              r_vol  [VOICES];
    logic                    r_act  [VOICES];
    logic [COUNTER_BITS-1:0] r_cnt  [VOICES];
    logic                    r_lvl  [VOICES];
    logic [1:0]              r_lt;
    logic                    r_white;
    logic [1:0]              r_rate;
    logic [14:0]             r_lfsr;

    // Sequencer
    logic [3:0]         r_state;
    logic [1:0]         r_t;
    logic [1:0]         r_idx;
    logic [15:0]        r_thr;
    logic signed [10:0] r_total;
    logic               r_ovalid;
    logic [7:0]         r_sample;

    t_div_req div_req;
    t_div_rsp div_rsp;

    psg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- APB ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_RATE: prdata = {16'd0, r_sr};
            REG_ODIV: prdata = {24'd0, r_odiv};
            REG_TUNE: prdata = {20'd0, r_tune};
            REG_FRAC: prdata = {31'd0, r_fe};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr   <= 16'd22050;
            r_odiv <= 8'd3;
            r_tune <= '0;
            r_fe   <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_RATE: r_sr   <= pwdata[15:0];
                REG_ODIV: r_odiv <= pwdata[7:0];
                REG_TUNE: r_tune <= pwdata[11:0];
                REG_FRAC: r_fe   <= pwdata[0];
                default:  ;
            endcase
        end
    end

    // ---------------- Datapath helpers ----------------
    logic       in_xfer;
    logic       out_free;
    logic [7:0] wb;
    logic [3:0] att;
    logic [1:0] lat_t;
    logic [1:0] vsel;

    assign in_xfer  = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_ovalid || o_smp.ready;
    assign wb       = i_cmd.write_byte;
    assign att      = wb[3:0];
    assign lat_t    = 2'd2 - wb[6:5];
    assign vsel     = (wb[6:4] == LATCH_NOISE_ATT) ? 2'd0 : lat_t + 2'd1;

    // Tone step for voice r_idx+1
    logic [1:0]              tv;
    logic [COUNTER_BITS-1:0] n_tcnt;
    logic [1:0]              n_extra;
    logic                    n_thit;
    logic [9:0]              n_acc;
    logic signed [10:0]      n_tsv;

    assign tv = r_idx + 2'd1;

    always_comb begin
        n_tcnt  = (r_cnt[tv] == CNT_MAX) ? r_cnt[tv] : r_cnt[tv] + 1'b1;
        n_extra = r_fe ? r_acc[r_idx][9:8] : 2'd0;
        n_thit  = (r_hp[r_idx] != NEVER) &&
                  ({1'b0, n_tcnt} >= ({1'b0, r_hp[r_idx]} + {15'd0, n_extra}));
        n_acc   = r_acc[r_idx] + {2'd0, r_frac[r_idx]} - {n_extra, 8'd0};
        n_tsv   = r_lvl[tv] ? $signed({4'd0, r_vol[tv]}) : -$signed({4'd0, r_vol[tv]});
    end

    // Noise step
    logic [COUNTER_BITS-1:0] n_ncnt;
    logic [19:0]             n_nthr;
    logic                    n_noff;
    logic                    n_nhit;
    logic signed [10:0]      n_nsv;

    always_comb begin
        n_ncnt = (r_cnt[0] == CNT_MAX) ? r_cnt[0] : r_cnt[0] + 1'b1;
        n_noff = (r_rate == 2'd3) && (r_hp[0] == NEVER);
        if (r_rate != 2'd3) begin
            n_nthr = {4'd0, r_thr};
        end else if (!r_white && r_lvl[0]) begin
            n_nthr = {r_hp[0], 4'd0};
        end else begin
            n_nthr = {4'd0, r_hp[0]};
        end
        n_nhit = !n_noff && ({4'd0, n_ncnt} >= n_nthr);
        n_nsv  = r_lvl[0] ? $signed({4'd0, r_vol[0]}) : -$signed({4'd0, r_vol[0]});
    end

    // Mix scaling: magnitude divided by four, sign reapplied after the divide.
    logic               mix_neg;
    logic signed [10:0] mix_abs;
    logic [6:0]         mix_mag;
    logic [7:0]         odiv_eff;
    logic [6:0]         oq;

    assign mix_neg  = r_total[10];
    assign mix_abs  = mix_neg ? -r_total : r_total;
    assign mix_mag  = mix_abs[8:2];
    assign odiv_eff = (r_odiv == 8'd0) ? 8'd1 : r_odiv;
    assign oq       = div_rsp.quotient[6:0];

    // Half-period from the second quotient plus the tuning offset, clamped at zero.
    logic signed [18:0] hp_v;
    logic [16:0]        freq;

    assign freq = div_rsp.quotient[DIVS_W-1:0];
    assign hp_v = $signed({2'd0, div_rsp.quotient[16:0]}) + 19'(r_tune);

    always_comb begin
        div_req = '0;
        div_req.divisor = DIVS_W'(1);
        unique case (r_state)
            S_FSTART: begin
                div_req.start    = (r_tdiv[r_t] != 10'd0);
                div_req.dividend = DIVD_W'(TONE_NUMER);
                div_req.divisor  = {7'd0, r_tdiv[r_t]};
            end
            S_FWAIT: begin
                div_req.start    = div_rsp.done && ({1'b0, r_sr} >= freq) &&
                                   ({2'b0, r_sr[15:1]} >= freq);
                div_req.dividend = {r_sr, 7'd0};
                div_req.divisor  = freq;
            end
            S_NSTART: begin
                div_req.start    = 1'b1;
                div_req.dividend = {7'd0, r_sr};
                div_req.divisor  = {3'd0, f_noise_div(r_white, r_lvl[0], r_rate)};
            end
            S_OSTART: begin
                div_req.start    = 1'b1;
                div_req.dividend = {16'd0, mix_mag};
                div_req.divisor  = {9'd0, odiv_eff};
            end
            default: ;
        endcase
    end

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign o_smp.valid  = r_ovalid;
    assign o_smp.sample = r_sample;

    // ---------------- Output valid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_smp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // ---------------- Sequencer and voice state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_t      <= '0;
            r_idx    <= '0;
            r_lt     <= '0;
            r_white  <= 1'b0;
            r_rate   <= '0;
            r_lfsr   <= 15'h4000;
            for (int t = 0; t < TONES; t++) begin
                r_tdiv[t] <= 10'd1000;
                r_hp[t]   <= NEVER;
                r_frac[t] <= '0;
                r_acc[t]  <= '0;
            end
            for (int v = 0; v < VOICES; v++) begin
                r_vol[v] <= (v == 0) ? 7'd0 : 7'd120;
                r_act[v] <= 1'b0;
                r_cnt[v] <= '0;
                r_lvl[v] <= 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_cmd.command) begin
                        r_total <= '0;
                        r_state <= S_NSTART;
                    end else if (in_xfer && !wb[7]) begin
                        r_tdiv[r_lt] <= {wb[5:0], r_tdiv[r_lt][3:0]};
                        r_t          <= r_lt;
                        r_state      <= S_FSTART;
                    end else if (in_xfer) begin
                        if (wb[6:4] == LATCH_NOISE_MODE) begin
                            r_rate  <= wb[1:0];
                            r_white <= wb[2];
                        end else begin
                            if (wb[6:4] != LATCH_NOISE_ATT) begin
                                r_lt <= lat_t;
                            end
                            if (wb[6:4] != LATCH_NOISE_ATT && !wb[4]) begin
                                r_tdiv[lat_t] <= {r_tdiv[lat_t][9:4], att};
                                r_t           <= lat_t;
                                r_state       <= S_FSTART;
                            end else begin
                                if (r_vol[vsel] == 7'd0 && att != 4'hF) begin
                                    r_act[vsel] <= 1'b1;
                                end
                                if (r_vol[vsel] != 7'd0 && att == 4'hF) begin
                                    r_act[vsel] <= 1'b0;
                                end
                                r_vol[vsel] <= {4'hF - att, 3'd0};
                            end
                        end
                    end
                end
                S_FSTART: begin
                    r_acc[r_t]  <= '0;
                    r_frac[r_t] <= '0;
                    if (r_tdiv[r_t] == 10'd0) begin
                        r_hp[r_t] <= NEVER;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    if (div_rsp.done) begin
                        if (freq > {1'b0, r_sr}) begin
                            r_hp[r_t] <= NEVER;
                            r_state   <= S_IDLE;
                        end else if (freq > {2'b0, r_sr[15:1]}) begin
                            r_hp[r_t] <= HP_W'(2);
                            r_state   <= S_IDLE;
                        end else begin
                            r_state <= S_QWAIT;
                        end
                    end
                end
                S_QWAIT: begin
                    if (div_rsp.done) begin
                        if (hp_v < 0) begin
                            r_hp[r_t]   <= '0;
                            r_frac[r_t] <= '0;
                        end else begin
                            r_hp[r_t]   <= {5'd0, hp_v[18:8]};
                            r_frac[r_t] <= hp_v[7:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_NSTART: r_state <= S_NWAIT;
                S_NWAIT: begin
                    if (div_rsp.done) begin
                        r_thr   <= div_rsp.quotient[15:0];
                        r_idx   <= '0;
                        r_state <= S_TONE;
                    end
                end
                S_TONE: begin
                    if (r_act[tv]) begin
                        r_total <= r_total + n_tsv;
                        if (n_thit) begin
                            r_cnt[tv] <= '0;
                            r_lvl[tv] <= !r_lvl[tv];
                            if (r_fe) begin
                                r_acc[r_idx] <= n_acc;
                            end
                        end else begin
                            r_cnt[tv] <= n_tcnt;
                        end
                    end
                    r_idx   <= r_idx + 2'd1;
                    r_state <= (r_idx == 2'(TONES - 1)) ? S_NOISE : S_TONE;
                end
                S_NOISE: begin
                    if (r_act[0]) begin
                        r_total <= r_total + n_nsv;
                        if (n_nhit) begin
                            r_cnt[0] <= '0;
                            if (r_white) begin
                                r_lvl[0] <= r_lfsr[0];
                                r_lfsr   <= {r_lfsr[0] ^ r_lfsr[1], r_lfsr[14:1]};
                            end else begin
                                r_lvl[0] <= !r_lvl[0];
                            end
                        end else begin
                            r_cnt[0] <= n_ncnt;
                        end
                    end
                    r_state <= S_OSTART;
                end
                S_OSTART: r_state <= S_OWAIT;
                S_OWAIT: begin
                    if (div_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The quotient stays in the divider until its next start, so S_OUT reads it directly.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_sample <= mix_neg ? 8'd128 - {1'b0, oq} : 8'd128 + {1'b0, oq};
        end
    end

    // ---------------- Assertions ----------------
    a_acc_below_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_acc[0][9] || r_acc[1][9] || r_acc[2][9]))
        else $error("fraction accumulator exceeded one carry");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_state == S_FWAIT || r_state == S_QWAIT ||
                          r_state == S_NWAIT || r_state == S_OWAIT))
        else $error("divider busy outside a wait state");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished sample not presented");

    a_never_no_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_hp[0] != NEVER || r_frac[0] == 8'd0) &&
                                 (r_hp[1] != NEVER || r_frac[1] == 8'd0) &&
                                 (r_hp[2] != NEVER || r_frac[2] == 8'd0)))
        else $error("silent tone holds a fractional half-period");

endmodule
